@@ rtl/rftm_pkg.sv @@
`default_nettype none

package rftm_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 10;
	localparam int HIT_W       = 32;

	// Fixed attributes of the local entry.
	localparam logic [1:0] LOCAL_PORT     = 2'd3;
	localparam logic [3:0] LOCAL_PRIORITY = 4'd4;
	localparam logic [HIT_W-1:0] HIT_MAX  = {HIT_W{1'b1}};

	// Input item actions.
	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_LOCAL   = 3'd0;
	localparam logic [2:0] ST_DROPPED = 3'd1;
	localparam logic [2:0] ST_RELAY   = 3'd2;
	localparam logic [2:0] ST_MISS    = 3'd3;
	localparam logic [2:0] ST_ADDED   = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;
	localparam logic [2:0] ST_READ_OK = 3'd6;
	localparam logic [2:0] ST_BAD_IDX = 3'd7;

	// Configuration register indexes.
	localparam logic CFG_LOCAL_LOW  = 1'b0;
	localparam logic CFG_LOCAL_HIGH = 1'b1;

	// One stored rule.
	typedef struct packed {
		logic [ADDR_W-1:0] low;
		logic [ADDR_W-1:0] high;
		logic              drop;
		logic [1:0]        port;
		logic [3:0]        prio;
	} rule_t;

endpackage

`default_nettype wire

@@ rtl/range_flow_table_match.sv @@
// Lookup: entries are fetched and checked in order from entry zero; the first hit ends the
// scan, a miss ends after the last used entry (64 at most). Add and read: one fetch and check.
// One item is processed at a time; the next item is taken the cycle after the result is
// registered. The scan is set by the single rule and hit-count memory read port.
// Reset clears the sequencer, the output valid, both range registers and the entry count
// (one entry, the local one); table memories are not cleared, since unwritten rows are never read.
`default_nettype none

module range_flow_table_match import rftm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write port.
	input  wire logic              cfg_write,
	input  wire logic              cfg_index,
	input  wire logic [ADDR_W-1:0] cfg_data,
	// Input channel.
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        action,
	input  wire logic [ADDR_W-1:0] dest_addr,
	input  wire logic [ADDR_W-1:0] rule_low,
	input  wire logic [ADDR_W-1:0] rule_high,
	input  wire logic              rule_drop,
	input  wire logic [1:0]        rule_port,
	input  wire logic [3:0]        rule_priority,
	input  wire logic [IDX_W-1:0]  read_index,
	// Output channel.
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [2:0]             status,
	output logic [1:0]             out_port,
	output logic [IDX_W-1:0]       entry_number,
	output logic [ADDR_W-1:0]      entry_low,
	output logic [ADDR_W-1:0]      entry_high,
	output logic                   entry_drop,
	output logic [3:0]             entry_priority,
	output logic [HIT_W-1:0]       entry_hits
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FETCH = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

	logic [1:0]        state_q;
	logic [1:0]        op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  used_q;
	logic [ADDR_W-1:0] local_low_q;
	logic [ADDR_W-1:0] local_high_q;
	logic [HIT_W-1:0]  hit0_q;
	logic [ADDR_W-1:0] dest_q;
	rule_t             new_rule_q;
	logic              out_valid_q;

	rule_t             rule_mem [TABLE_DEPTH];
	logic [HIT_W-1:0]  hit_mem  [TABLE_DEPTH];
	rule_t             rule_rd_q;
	logic [HIT_W-1:0]  hit_rd_q;

	logic              in_accept;
	logic              out_free;
	rule_t             cur_rule;
	logic [HIT_W-1:0]  cur_hits;
	logic [HIT_W-1:0]  hits_inc;
	logic              in_range;
	logic [CNT_W-1:0]  idx_next;
	logic              finish;
	logic              advance;
	logic              rule_we;
	logic              hit_we;
	logic              hit0_we;
	logic [IDX_W-1:0]  hit_wa;
	logic [HIT_W-1:0]  hit_wd;
	logic [2:0]        res_status;
	logic [1:0]        res_port;
	logic [IDX_W-1:0]  res_number;
	rule_t             res_rule;
	logic [HIT_W-1:0]  res_hits;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Current entry: entry zero comes from the range registers, others from memory.
	always_comb begin
		if (idx_q == '0) begin
			cur_rule.low  = local_low_q;
			cur_rule.high = local_high_q;
			cur_rule.drop = 1'b0;
			cur_rule.port = LOCAL_PORT;
			cur_rule.prio = LOCAL_PRIORITY;
			cur_hits      = hit0_q;
		end else begin
			cur_rule = rule_rd_q;
			cur_hits = hit_rd_q;
		end
	end

	// Shared range compare and saturating increment.
	assign in_range = (cur_rule.low <= dest_q) && (dest_q <= cur_rule.high);
	assign hits_inc = (cur_hits == HIT_MAX) ? cur_hits : cur_hits + HIT_W'(1);
	assign idx_next = {1'b0, idx_q} + CNT_ONE;

	// Decision taken on the fetched entry.
	always_comb begin
		finish     = 1'b0;
		advance    = 1'b0;
		rule_we    = 1'b0;
		hit_we     = 1'b0;
		hit0_we    = 1'b0;
		hit_wa     = idx_q;
		hit_wd     = hits_inc;
		res_status = ST_MISS;
		res_port   = '0;
		res_number = '0;
		res_rule   = '0;
		res_hits   = '0;
		if (state_q == S_CHECK) begin
			case (op_q)
				ACT_LOOKUP: begin
					if (in_range) begin
						finish     = out_free;
						hit_we     = out_free && (idx_q != '0);
						hit0_we    = out_free && (idx_q == '0);
						res_number = idx_q;
						res_rule   = cur_rule;
						res_hits   = hits_inc;
						if (cur_rule.drop) begin
							res_status = ST_DROPPED;
						end else if (cur_rule.port == LOCAL_PORT) begin
							res_status = ST_LOCAL;
						end else begin
							res_status = ST_RELAY;
							res_port   = cur_rule.port;
						end
					end else if (idx_next >= used_q) begin
						finish     = out_free;
						res_status = ST_MISS;
					end else begin
						advance = 1'b1;
					end
				end
				ACT_ADD: begin
					finish = out_free;
					if (used_q >= DEPTH_CNT) begin
						res_status = ST_FULL;
					end else begin
						rule_we    = out_free;
						hit_we     = out_free;
						hit_wa     = used_q[IDX_W-1:0];
						hit_wd     = '0;
						res_status = ST_ADDED;
						res_number = used_q[IDX_W-1:0];
						res_rule   = new_rule_q;
					end
				end
				default: begin
					finish = out_free;
					if ({1'b0, idx_q} >= used_q) begin
						res_status = ST_BAD_IDX;
					end else begin
						res_status = ST_READ_OK;
						res_number = idx_q;
						res_rule   = cur_rule;
						res_hits   = cur_hits;
					end
				end
			endcase
		end
	end

	// Sequencer, entry count, range registers and local hit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= ACT_LOOKUP;
			idx_q        <= '0;
			used_q       <= CNT_ONE;
			local_low_q  <= '0;
			local_high_q <= '0;
			hit0_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_LOCAL_LOW:  local_low_q  <= cfg_data;
					CFG_LOCAL_HIGH: local_high_q <= cfg_data;
					default:        local_low_q  <= local_low_q;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end
			if (rule_we) begin
				used_q <= used_q + CNT_ONE;
			end
			if (hit0_we) begin
				hit0_q <= hits_inc;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept && action != ACT_NONE) begin
						op_q    <= action;
						idx_q   <= (action == ACT_READ) ? read_index : '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (finish) begin
						state_q <= S_IDLE;
					end else if (advance) begin
						idx_q   <= idx_next[IDX_W-1:0];
						state_q <= S_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload held for the operation.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			dest_q          <= dest_addr;
			new_rule_q.low  <= rule_low;
			new_rule_q.high <= rule_high;
			new_rule_q.drop <= rule_drop;
			new_rule_q.port <= rule_port;
			new_rule_q.prio <= rule_priority;
		end
	end

	// Rule memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (rule_we) begin
			rule_mem[used_q[IDX_W-1:0]] <= new_rule_q;
		end
		rule_rd_q <= rule_mem[idx_q];
	end

	// Hit count memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (hit_we) begin
			hit_mem[hit_wa] <= hit_wd;
		end
		hit_rd_q <= hit_mem[idx_q];
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (finish) begin
			status         <= res_status;
			out_port       <= res_port;
			entry_number   <= res_number;
			entry_low      <= res_rule.low;
			entry_high     <= res_rule.high;
			entry_drop     <= res_rule.drop;
			entry_priority <= res_rule.prio;
			entry_hits     <= res_hits;
		end
	end

endmodule

`default_nettype wire
